@@ design/rfft_pkg.sv @@
`default_nettype none
package rfft_pkg;

    localparam int DATA_W    = 24;
    localparam int SAMPLE_W  = 16;
    localparam int MAX_LOG   = 6;
    localparam int IDX_W     = 6;
    localparam int ROM_POINTS = 64;
    localparam int ROM_SCALE_BITS = 24;
    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_TWIDDLE_BITS = 16;

    localparam logic [1:0] CFG_INVERSE = 2'd0;
    localparam logic [1:0] CFG_SIZE    = 2'd1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD,
        S_MUL,
        S_WR,
        S_ORD,
        S_OUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic              load_we;
        logic [IDX_W-1:0]  load_addr;
        logic              rd_en;
        logic [IDX_W-1:0]  addr_u;
        logic [IDX_W-1:0]  addr_v;
        logic [IDX_W-1:0]  tw_idx;
        logic              mul_en;
        logic              bf_we;
        logic              out_rd;
        logic              out_load;
        logic [IDX_W-1:0]  out_index;
        logic              out_last;
        logic              inv;
        logic [2:0]        log_n;
    } t_cmd;

    // quarter-wave cosine magnitudes scaled by 2^24
    function automatic logic [24:0] quarter_cos(input logic [4:0] q);
        logic [24:0] v;
        case (q)
            5'd0:  v = 25'd16777216;
            5'd1:  v = 25'd16696429;
            5'd2:  v = 25'd16454846;
            5'd3:  v = 25'd16054795;
            5'd4:  v = 25'd15500126;
            5'd5:  v = 25'd14796184;
            5'd6:  v = 25'd13949745;
            5'd7:  v = 25'd12968963;
            5'd8:  v = 25'd11863283;
            5'd9:  v = 25'd10643353;
            5'd10: v = 25'd9320922;
            5'd11: v = 25'd7908725;
            5'd12: v = 25'd6420363;
            5'd13: v = 25'd4870169;
            5'd14: v = 25'd3273072;
            5'd15: v = 25'd1644455;
            default: v = 25'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ design/radix2_fft_frame.sv @@
// Radix-2 DIT FFT over one frame of up to MAX_POINTS (at most 64) complex samples.
// Samples are taken one per cycle into a bit-reversed work store; after the N-th
// sample the input stalls while one butterfly unit runs (N/2)*log2(N) butterflies,
// each in a read, a multiply and a write state, then N bins leave in natural order,
// each read into a register and then loaded into the output register when it is free.
`default_nettype none
module radix2_fft_frame #(
    parameter int MAX_POINTS   = rfft_pkg::DEF_MAX_POINTS,
    parameter int TWIDDLE_BITS = rfft_pkg::DEF_TWIDDLE_BITS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire signed [15:0] i_sample_re,
    input  wire signed [15:0] i_sample_im,
    output logic        o_valid,
    input  wire         i_stall,
    output logic signed [23:0] o_bin_re,
    output logic signed [23:0] o_bin_im,
    output logic [5:0]  o_bin_index,
    output logic        o_last_bin,
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [2:0]  i_cfg_data
);
    import rfft_pkg::*;

    logic       r_inverse;
    logic [2:0] r_size;
    t_cmd       cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inverse <= 1'b0;
            r_size    <= 3'd6;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_INVERSE) r_inverse <= i_cfg_data[0];
            else if (i_cfg_index == CFG_SIZE) r_size <= i_cfg_data;
        end
    end

    rfft_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_inverse   (r_inverse),
        .i_size_log2 (r_size),
        .o_cmd       (cmd)
    );

    rfft_dp #(.MAX_POINTS(MAX_POINTS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_dp (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_re    (i_sample_re),
        .i_im    (i_sample_im),
        .o_re    (o_bin_re),
        .o_im    (o_bin_im),
        .o_index (o_bin_index),
        .o_last  (o_last_bin)
    );

endmodule
`default_nettype wire

@@ design/rfft_ctrl.sv @@
`default_nettype none
module rfft_ctrl #(
    parameter int MAX_POINTS = rfft_pkg::DEF_MAX_POINTS
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  wire                  i_stall,
    input  wire                  i_inverse,
    input  wire  [2:0]           i_size_log2,
    output rfft_pkg::t_cmd       o_cmd
);
    import rfft_pkg::*;

    // log2 of the largest power of two that fits in MAX_POINTS, capped at 64 points
    localparam int MAXL = (MAX_POINTS >= 64) ? 6 : ($clog2(MAX_POINTS + 1) - 1);

    t_state           r_state, n_state;
    logic [6:0]       r_cnt, n_cnt;       // load count
    logic [2:0]       r_stage, n_stage;   // butterfly stage 0..L-1
    logic [4:0]       r_bf, n_bf;         // butterfly within stage
    logic [IDX_W:0]   r_k, n_k;           // output bin
    logic             r_inv, n_inv;
    logic [2:0]       r_l, n_l;
    logic             r_ovalid, n_ovalid;

    logic [2:0] eff_l;
    logic [6:0] npts;
    logic [IDX_W-1:0] laddr, lmask, cmasked;
    logic [IDX_W-1:0] half, lowk, ua;
    logic [5:0] bf_last;

    // clamp requested size
    always_comb begin
        eff_l = i_size_log2;
        if (eff_l < 3'd1) eff_l = 3'd1;
        if (eff_l > 3'(MAXL)) eff_l = 3'(MAXL);
    end

    // bit-reversed load address
    always_comb begin
        npts = 7'd1 << eff_l;
        lmask = IDX_W'(npts - 7'd1);
        cmasked = r_cnt[IDX_W-1:0] & lmask;
        laddr = '0;
        for (int b = 0; b < IDX_W; b++) begin
            if (b < int'(eff_l)) laddr[int'(eff_l) - 1 - b] = cmasked[b];
        end
    end

    // butterfly addressing: group/offset split of the butterfly count
    always_comb begin
        half = IDX_W'(1) << r_stage;
        lowk = IDX_W'(r_bf) & (half - IDX_W'(1));
        ua = ((IDX_W'(r_bf) & ~(half - IDX_W'(1))) << 1) | lowk;
        bf_last = 6'((7'd1 << r_l) >> 1) - 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_cnt    <= '0;
            r_stage  <= '0;
            r_bf     <= '0;
            r_k      <= '0;
            r_inv    <= 1'b0;
            r_l      <= 3'd1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_stage  <= n_stage;
            r_bf     <= n_bf;
            r_k      <= n_k;
            r_inv    <= n_inv;
            r_l      <= n_l;
            r_ovalid <= n_ovalid;
        end
    end

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_stage  = r_stage;
        n_bf     = r_bf;
        n_k      = r_k;
        n_inv    = r_inv;
        n_l      = r_l;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        o_cmd.inv   = r_inv;
        o_cmd.log_n = r_l;
        o_cmd.addr_u = ua;
        o_cmd.addr_v = ua + half;
        o_cmd.tw_idx = IDX_W'(lowk << (3'd5 - r_stage));
        o_cmd.load_addr = laddr;
        o_cmd.out_index = r_k[IDX_W-1:0];
        o_cmd.out_last  = (r_k + 1'b1) == ((IDX_W+1)'(1) << r_l);
        o_stall = 1'b1;
        if (i_stall == 1'b0) n_ovalid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load_we = 1'b1;
                    n_cnt = r_cnt + 7'd1;
                    if ((r_cnt + 7'd1) >= npts) begin
                        n_cnt   = '0;
                        n_inv   = i_inverse;
                        n_l     = eff_l;
                        n_stage = '0;
                        n_bf    = '0;
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.bf_we = 1'b1;
                n_state = S_RD;
                if (6'(r_bf) == bf_last) begin
                    n_bf = '0;
                    if (r_stage + 3'd1 == r_l) begin
                        n_k = '0;
                        n_state = S_ORD;
                    end else begin
                        n_stage = r_stage + 3'd1;
                    end
                end else begin
                    n_bf = r_bf + 5'd1;
                end
            end
            S_ORD: begin
                // read bin into datapath read register
                o_cmd.out_rd = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_k = r_k + 1'b1;
                    n_state = o_cmd.out_last ? S_LOAD : S_ORD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    assign o_valid = r_ovalid;

    a_load_only_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_we |-> r_state == S_LOAD) else $error("load outside load state");
    a_no_new_result_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |-> !o_cmd.out_load) else $error("result overwritten");
    a_stage_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WR |-> r_stage < r_l) else $error("stage out of range");

endmodule
`default_nettype wire

@@ design/rfft_dp.sv @@
`default_nettype none
module rfft_dp #(
    parameter int MAX_POINTS   = rfft_pkg::DEF_MAX_POINTS,
    parameter int TWIDDLE_BITS = rfft_pkg::DEF_TWIDDLE_BITS
) (
    input  wire                               i_clk,
    input  rfft_pkg::t_cmd                    i_cmd,
    input  wire signed [rfft_pkg::SAMPLE_W-1:0] i_re,
    input  wire signed [rfft_pkg::SAMPLE_W-1:0] i_im,
    output logic signed [rfft_pkg::DATA_W-1:0]  o_re,
    output logic signed [rfft_pkg::DATA_W-1:0]  o_im,
    output logic [rfft_pkg::IDX_W-1:0]          o_index,
    output logic                                o_last
);
    import rfft_pkg::*;

    localparam int FRAC = TWIDDLE_BITS - 1;
    localparam int SH   = ROM_SCALE_BITS - FRAC;
    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PW   = DATA_W + TWIDDLE_BITS + 2;
    localparam logic signed [PW-1:0] RND = PW'(1) <<< (FRAC - 1);
    localparam logic signed [PW:0] DMAX = (PW+1)'(8388607);
    localparam logic signed [PW:0] DMIN = -(PW+1)'(8388608);

    // work store, one port each for u and v
    logic signed [DATA_W-1:0] mem_re [MAX_POINTS];
    logic signed [DATA_W-1:0] mem_im [MAX_POINTS];

    logic signed [DATA_W-1:0] r_ur, r_ui, r_vr, r_vi;
    logic signed [DATA_W-1:0] r_ur2, r_ui2;
    logic signed [PW-1:0]     r_tr, r_ti;
    logic signed [TWIDDLE_BITS-1:0] w_c, w_s;

    // twiddle magnitude from quarter table
    function automatic logic signed [TWIDDLE_BITS-1:0] mag(input logic [5:0] q);
        logic [24:0] m;
        logic [24:0] lim;
        m = (quarter_cos(q[4:0]) + (25'd1 << (SH - 1))) >> SH;
        lim = (25'd1 << FRAC) - 25'd1;
        if (m > lim) m = lim;
        return TWIDDLE_BITS'(m);
    endfunction

    function automatic logic signed [TWIDDLE_BITS-1:0] rcos(input logic [5:0] w);
        logic signed [TWIDDLE_BITS-1:0] r;
        if (w <= 6'd16)      r = mag(w);
        else if (w <= 6'd32) r = -mag(6'd32 - w);
        else if (w <= 6'd48) r = -mag(w - 6'd32);
        else                 r = mag(6'(7'd64 - 7'(w)));
        return r;
    endfunction

    // clamp to the 24-bit data range
    function automatic logic signed [DATA_W-1:0] sat(input logic signed [PW-1:0] x);
        logic signed [PW:0] e;
        e = (PW+1)'(x);
        if (e > DMAX) return DATA_W'(24'sd8388607);
        if (e < DMIN) return DATA_W'(-24'sd8388608);
        return DATA_W'(x);
    endfunction

    always_comb begin
        w_c = rcos(i_cmd.tw_idx);
        w_s = rcos(i_cmd.tw_idx + 6'd48);
        if (!i_cmd.inv) w_s = -w_s;
    end

    // memory writes: load or butterfly result; reads registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            mem_re[AW'(i_cmd.load_addr)] <= DATA_W'(i_re);
            mem_im[AW'(i_cmd.load_addr)] <= DATA_W'(i_im);
        end
        if (i_cmd.bf_we) begin
            mem_re[AW'(i_cmd.addr_u)] <= sat(PW'(r_ur2) + r_tr);
            mem_im[AW'(i_cmd.addr_u)] <= sat(PW'(r_ui2) + r_ti);
            mem_re[AW'(i_cmd.addr_v)] <= sat(PW'(r_ur2) - r_tr);
            mem_im[AW'(i_cmd.addr_v)] <= sat(PW'(r_ui2) - r_ti);
        end
        if (i_cmd.rd_en || i_cmd.out_rd) begin
            r_ur <= mem_re[AW'(i_cmd.out_rd ? i_cmd.out_index : i_cmd.addr_u)];
            r_ui <= mem_im[AW'(i_cmd.out_rd ? i_cmd.out_index : i_cmd.addr_u)];
            r_vr <= mem_re[AW'(i_cmd.addr_v)];
            r_vi <= mem_im[AW'(i_cmd.addr_v)];
        end
    end

    // complex multiply with rounding
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_tr <= (PW'(r_vr) * PW'(w_c) - PW'(r_vi) * PW'(w_s) + RND) >>> FRAC;
            r_ti <= (PW'(r_vr) * PW'(w_s) + PW'(r_vi) * PW'(w_c) + RND) >>> FRAC;
            r_ur2 <= r_ur;
            r_ui2 <= r_ui;
        end
    end

    // output register with inverse scaling
    logic signed [DATA_W:0] half_v, sr, si;
    always_comb begin
        half_v = (DATA_W+1)'(1) <<< (i_cmd.log_n - 3'd1);
        sr = ((DATA_W+1)'(r_ur) + half_v) >>> i_cmd.log_n;
        si = ((DATA_W+1)'(r_ui) + half_v) >>> i_cmd.log_n;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_re    <= i_cmd.inv ? DATA_W'(sr) : r_ur;
            o_im    <= i_cmd.inv ? DATA_W'(si) : r_ui;
            o_index <= i_cmd.out_index;
            o_last  <= i_cmd.out_last;
        end
    end

endmodule
`default_nettype wire
